/* sv/lce_pkg.sv */
// Package for the load-and-call executor: types, opcodes, constants.
// No dependencies.
`timescale 1ns / 1ps
package lce_pkg;
    localparam int MEM_BYTES_DEF = 65536;
    localparam logic [15:0] PC_RESET = 16'hFFFC;
    localparam logic [7:0]  SP_RESET = 8'hFF;
    localparam logic [7:0]  STACK_PAGE = 8'h01;

    localparam logic [7:0] OP_JSR    = 8'h20;
    localparam logic [7:0] OP_LDA_IM = 8'hA9;
    localparam logic [7:0] OP_LDA_ZP = 8'hA5;
    localparam logic [7:0] OP_LDA_ZX = 8'hB5;
    localparam logic [7:0] OP_LDA_AB = 8'hAD;
    localparam logic [7:0] OP_LDA_AX = 8'hBD;
    localparam logic [7:0] OP_LDA_AY = 8'hB9;
    localparam logic [7:0] OP_LDA_IX = 8'hA1;
    localparam logic [7:0] OP_LDA_IY = 8'hB1;
    localparam logic [7:0] OP_LDX_IM = 8'hA2;
    localparam logic [7:0] OP_LDX_ZP = 8'hA6;
    localparam logic [7:0] OP_LDX_ZY = 8'hB6;
    localparam logic [7:0] OP_LDX_AB = 8'hAE;
    localparam logic [7:0] OP_LDX_AY = 8'hBE;
    localparam logic [7:0] OP_LDY_IM = 8'hA0;
    localparam logic [7:0] OP_LDY_ZP = 8'hA4;
    localparam logic [7:0] OP_LDY_ZX = 8'hB4;
    localparam logic [7:0] OP_LDY_AB = 8'hAC;
    localparam logic [7:0] OP_LDY_AX = 8'hBC;

    typedef enum logic [3:0] {
        M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY, M_JSR, M_BAD
    } t_mode;
    typedef enum logic [1:0] {D_A, D_X, D_Y} t_dst;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_OP, S_DEC, S_B1, S_B2, S_P1, S_P2, S_P3, S_PUSH_H, S_PUSH_L,
        S_DATA, S_DONE, S_OUT
    } t_state;

    // address source for the memory port
    typedef enum logic [2:0] {A_CLR, A_CMD, A_PC, A_ZP, A_ZP1, A_EA, A_STK} t_asel;

    typedef struct packed {
        logic   clr_inc;
        logic   mem_we;
        logic   wr_cmd;    // write comes from the command beat
        logic   wr_hi;     // stack push of return address high byte
        t_asel  asel;
        logic   pc_inc;
        logic   lat_op;
        logic   lat_b1;
        logic   lat_b2;
        logic   lat_p1;
        logic   lat_p2;
        logic   do_load;
        logic   do_jsr;
        logic   set_ill;
        logic   start;     // clear per-beat result fields
    } t_ctl;

    typedef struct packed {
        logic   clr_done;
        t_mode  mode;
    } t_sts;

    function automatic t_mode op_mode(input logic [7:0] op);
        unique case (op)
            OP_JSR: return M_JSR;
            OP_LDA_IM, OP_LDX_IM, OP_LDY_IM: return M_IMM;
            OP_LDA_ZP, OP_LDX_ZP, OP_LDY_ZP: return M_ZP;
            OP_LDA_ZX, OP_LDY_ZX: return M_ZPX;
            OP_LDX_ZY: return M_ZPY;
            OP_LDA_AB, OP_LDX_AB, OP_LDY_AB: return M_ABS;
            OP_LDA_AX, OP_LDY_AX: return M_ABSX;
            OP_LDA_AY, OP_LDX_AY: return M_ABSY;
            OP_LDA_IX: return M_INDX;
            OP_LDA_IY: return M_INDY;
            default: return M_BAD;
        endcase
    endfunction

    function automatic t_dst op_dst(input logic [7:0] op);
        unique case (op[1:0])
            2'b10:   return D_X;
            2'b00:   return D_Y;
            default: return D_A;
        endcase
    endfunction
endpackage

/* sv/lce_if.sv */
// Valid/ready channel carrying a packed payload.
// No dependencies.
`timescale 1ns / 1ps
interface lce_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/lce_ctrl.sv */
// Sequencer for the executor: steps each command through memory accesses.
// Depends on lce_pkg.
`timescale 1ns / 1ps
module lce_ctrl
    import lce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_cmd,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl = '0;
        o_ctl.asel = A_PC;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_ctl.asel = A_CLR;
                o_ctl.mem_we = 1'b1;
                o_ctl.clr_inc = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.start = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd) begin
                        n_state = S_OP;
                    end else begin
                        o_ctl.asel = A_CMD;
                        o_ctl.mem_we = i_in_valid;
                        o_ctl.wr_cmd = 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_OP: begin
                o_ctl.lat_op = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.mode == M_BAD) begin
                    o_ctl.set_ill = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_ctl.pc_inc = 1'b1;
                    n_state = S_B1;
                end
            end
            S_B1: begin
                o_ctl.lat_b1 = 1'b1;
                o_ctl.pc_inc = 1'b1;
                unique case (i_sts.mode)
                    M_IMM: n_state = S_DONE;
                    M_ZP, M_ZPX, M_ZPY: n_state = S_DATA;
                    M_INDX, M_INDY: n_state = S_P1;
                    default: n_state = S_B2;
                endcase
            end
            S_B2: begin
                o_ctl.lat_b2 = 1'b1;
                o_ctl.pc_inc = 1'b1;
                n_state = (i_sts.mode == M_JSR) ? S_PUSH_H : S_DATA;
            end
            S_P1: begin
                o_ctl.asel = A_ZP;
                n_state = S_P2;
            end
            S_P2: begin
                o_ctl.asel = A_ZP1;
                o_ctl.lat_p1 = 1'b1;
                n_state = S_P3;
            end
            S_P3: begin
                o_ctl.lat_p2 = 1'b1;
                n_state = S_DATA;
            end
            S_DATA: begin
                o_ctl.asel = A_EA;
                n_state = S_DONE;
            end
            S_PUSH_H: begin
                o_ctl.asel = A_STK;
                o_ctl.mem_we = 1'b1;
                o_ctl.wr_hi = 1'b1;
                n_state = S_PUSH_L;
            end
            S_PUSH_L: begin
                o_ctl.asel = A_STK;
                o_ctl.mem_we = 1'b1;
                o_ctl.do_jsr = 1'b1;
                n_state = S_OUT;
            end
            S_DONE: begin
                o_ctl.do_load = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* sv/lce_dp.sv */
// Datapath: memory, CPU registers and address generation.
// Depends on lce_pkg.
`timescale 1ns / 1ps
module lce_dp
    import lce_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctl                         i_ctl,
    input  logic [$clog2(MEM_BYTES)-1:0] i_addr,
    input  logic [7:0]                   i_data,
    output t_sts                         o_sts,
    output logic [7:0]                   o_acc,
    output logic [7:0]                   o_x,
    output logic [7:0]                   o_y,
    output logic [15:0]                  o_pc,
    output logic [7:0]                   o_sp,
    output logic                         o_z,
    output logic                         o_n,
    output logic [2:0]                   o_cyc,
    output logic                         o_ill
);
    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0]  r_mem [MEM_BYTES];
    logic [7:0]  r_rd;
    logic [AW-1:0] r_clr;
    logic [7:0]  r_a, r_x, r_y, r_sp, r_op, r_b1, r_b2, r_p1, r_p2;
    logic [15:0] r_pc;
    logic        r_z, r_n, r_ill;
    logic [2:0]  r_cyc;
    logic [15:0] n_ea, n_base, n_ret;
    logic [8:0]  n_sum;
    logic [7:0]  n_zp, n_zp1, n_wd, n_idx, n_ld;
    logic [AW-1:0] n_ad;
    t_mode       n_mode;
    logic        n_cross;

    assign n_mode = op_mode(r_op);
    assign n_zp = (n_mode == M_INDY || n_mode == M_ZP) ? r_b1
                : (n_mode == M_ZPY) ? r_b1 + r_y : r_b1 + r_x;
    assign n_zp1 = n_zp + 8'd1;
    assign n_idx = (n_mode == M_ABSY || n_mode == M_INDY) ? r_y : r_x;
    assign n_base = (n_mode == M_INDX || n_mode == M_INDY) ? {r_p2, r_p1} : {r_b2, r_b1};
    assign n_sum = {1'b0, n_base[7:0]} + {1'b0, n_idx};
    assign n_cross = n_sum[8];
    assign n_ld = (n_mode == M_IMM) ? r_b1 : r_rd;
    always_comb begin
        unique case (n_mode)
            M_ZP, M_ZPX, M_ZPY: n_ea = {8'h00, n_zp};
            M_ABS, M_INDX:      n_ea = n_base;
            default:            n_ea = {n_base[15:8] + {7'd0, n_sum[8]}, n_sum[7:0]};
        endcase
    end
    assign n_ret = r_pc - 16'd1;

    // an operand fetch reads the byte after PC as PC advances
    always_comb begin
        unique case (i_ctl.asel)
            A_CLR:   n_ad = r_clr;
            A_CMD:   n_ad = i_addr;
            A_ZP:    n_ad = AW'(n_zp);
            A_ZP1:   n_ad = AW'(n_zp1);
            A_EA:    n_ad = AW'(n_ea);
            A_STK:   n_ad = AW'({STACK_PAGE, r_sp});
            default: n_ad = AW'(r_pc + {15'd0, i_ctl.pc_inc});
        endcase
        if (i_ctl.asel == A_CLR)   n_wd = 8'h00;
        else if (i_ctl.wr_cmd)     n_wd = i_data;
        else if (i_ctl.wr_hi)      n_wd = n_ret[15:8];
        else                       n_wd = n_ret[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mem_we) r_mem[n_ad] <= n_wd;
        r_rd <= r_mem[n_ad];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.lat_op) r_op <= r_rd;
        if (i_ctl.lat_b1) r_b1 <= r_rd;
        if (i_ctl.lat_b2) r_b2 <= r_rd;
        if (i_ctl.lat_p1) r_p1 <= r_rd;
        if (i_ctl.lat_p2) r_p2 <= r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_a <= '0; r_x <= '0; r_y <= '0;
            r_pc <= PC_RESET; r_sp <= SP_RESET;
            r_z <= 1'b0; r_n <= 1'b0; r_ill <= 1'b0; r_cyc <= '0;
        end else begin
            if (i_ctl.clr_inc) r_clr <= r_clr + 1'b1;
            if (i_ctl.start) begin
                r_ill <= 1'b0;
                r_cyc <= '0;
            end
            if (i_ctl.set_ill) r_ill <= 1'b1;
            if (i_ctl.pc_inc) r_pc <= r_pc + 16'd1;
            if (i_ctl.wr_hi) r_sp <= r_sp - 8'd1;
            if (i_ctl.do_jsr) begin
                r_sp <= r_sp - 8'd1;
                r_pc <= {r_b2, r_b1};
                r_cyc <= 3'd6;
            end
            if (i_ctl.do_load) begin
                unique case (op_dst(r_op))
                    D_X:     r_x <= n_ld;
                    D_Y:     r_y <= n_ld;
                    default: r_a <= n_ld;
                endcase
                r_z <= (n_ld == 8'h00);
                r_n <= n_ld[7];
                unique case (n_mode)
                    M_IMM:          r_cyc <= 3'd2;
                    M_ZP:           r_cyc <= 3'd3;
                    M_ABSX, M_ABSY: r_cyc <= n_cross ? 3'd5 : 3'd4;
                    M_INDX:         r_cyc <= 3'd6;
                    M_INDY:         r_cyc <= n_cross ? 3'd6 : 3'd5;
                    default:        r_cyc <= 3'd4;
                endcase
            end
        end
    end

    assign o_sts.clr_done = (r_clr == {AW{1'b1}});
    assign o_sts.mode = n_mode;
    assign o_acc = r_a;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_pc = r_pc;
    assign o_sp = r_sp;
    assign o_z = r_z;
    assign o_n = r_n;
    assign o_cyc = r_cyc;
    assign o_ill = r_ill;
endmodule

/* sv/cpu_load_and_call_executor.sv */
// Top level of the load-and-call executor: sequencer plus datapath.
// Depends on lce_pkg, lce_if, lce_ctrl, lce_dp.
//
//  channel  dir  payload {msb..lsb}
//  s_in     in   cmd, addr[15:0], data[7:0]
//  m_out    out  acc, index_x, index_y, prog_counter, stack_ptr,
//                zero_flag, neg_flag, cycles_used[2:0], illegal
//
// A beat runs from input accept through result accept as a sequence of memory
// accesses, one access per cycle on the single memory port.
// After reset a clearing pass zeroes memory; no beat is taken.
// One beat at a time; the result holds until taken, and a stall on m_out
// holds off the next input beat.
`timescale 1ns / 1ps
module cpu_load_and_call_executor
    import lce_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lce_if.sink   s_in,
    lce_if.source m_out
);
    t_ctl w_ctl;
    t_sts w_sts;
    logic [$clog2(MEM_BYTES)-1:0] w_addr;

    assign w_addr = s_in.payload[8 +: $clog2(MEM_BYTES)];

    lce_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_in.valid),
        .i_in_cmd   (s_in.payload[24]),
        .o_in_ready (s_in.ready),
        .o_out_valid(m_out.valid),
        .i_out_ready(m_out.ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    lce_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
        .i_clk, .i_rst_n,
        .i_ctl (w_ctl),
        .i_addr(w_addr),
        .i_data(s_in.payload[7:0]),
        .o_sts (w_sts),
        .o_acc (m_out.payload[53:46]),
        .o_x   (m_out.payload[45:38]),
        .o_y   (m_out.payload[37:30]),
        .o_pc  (m_out.payload[29:14]),
        .o_sp  (m_out.payload[13:6]),
        .o_z   (m_out.payload[5]),
        .o_n   (m_out.payload[4]),
        .o_cyc (m_out.payload[3:1]),
        .o_ill (m_out.payload[0])
    );
endmodule
